/* hdl/csvfre_pkg.sv */
// Shared types, codes and constants of the CSV flight record extractor.
package csvfre_pkg;

  localparam int CODE_LENGTH_DEF = 3;
  localparam int COL_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int NUM_W   = 16;
  localparam int CODE_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  // Magnitude ceiling of the number accumulator and the signed limits.
  localparam logic [NUM_W-1:0] NUM_MAG_MAX = 16'h8000;
  localparam logic [NUM_W-1:0] NUM_POS_MAX = 16'h7FFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_COL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_COL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_COL   = 2'd3;

  localparam logic [COL_W-1:0] DAY_COL_RST    = 6'd1;
  localparam logic [COL_W-1:0] DELAY_COL_RST  = 6'd2;
  localparam logic [COL_W-1:0] ORIGIN_COL_RST = 6'd3;
  localparam logic [COL_W-1:0] DEST_COL_RST   = 6'd4;

  typedef enum logic [3:0] {
    LINE_PARSING  = 4'b0001,
    LINE_REJECTED = 4'b0010,
    LINE_COMPLETE = 4'b0100,
    LINE_STOPPED  = 4'b1000
  } line_state_t;

  typedef enum logic [3:0] {
    NUM_SPACE  = 4'b0001,
    NUM_SIGN   = 4'b0010,
    NUM_DIGITS = 4'b0100,
    NUM_DONE   = 4'b1000
  } num_phase_t;

  typedef struct packed {
    logic take;
    logic clear;
  } field_ctrl_t;

  typedef struct packed {
    logic              empty;
    logic              exact;
    logic [NUM_W-1:0]  number;
    logic [CODE_W-1:0] code;
  } field_stat_t;

endpackage

/* hdl/csv_flight_record_extractor_unit.sv */
// Top level of the CSV flight record extractor: beat registers, line control, result register.
// Usage
//   Feed one byte of a CSV text line per input beat (in_char_code), with in_line_end
//   high on the last byte. Commas are counted; the four column registers give the comma
//   count that closes the day, arrival delay, origin and destination fields.
//   On the beat that carries in_line_end exactly one result beat leaves the block:
//   out_record_status is 0 for an accepted record and 1 otherwise, with the day and
//   delay values (saturated signed) and both codes taken so far. Other beats give none.
// Timing
//   One byte per cycle sustained while no line end waits. A byte is accepted into the input
//   register, worked on by the field and line logic once it leaves that register, and for
//   a line end the result is then held in the output register.
//   The per-byte state update is the loop that sets the byte rate.
// Stall
//   While out_stall is high a waiting result holds. Bytes that do not end a line keep
//   flowing; a line end that finds the output register still occupied waits in the
//   input register, and in_stall rises only then.
// Reset
//   rst_n is synchronous, active low: columns return to 1..4, all line state clears,
//   and no beat is pending. Write configuration only while no beat is in flight.
module csv_flight_record_extractor_unit #(
  parameter int CODE_LENGTH = csvfre_pkg::CODE_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [csvfre_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                              in_line_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_record_status,
  output logic signed [csvfre_pkg::NUM_W-1:0] out_day_value,
  output logic signed [csvfre_pkg::NUM_W-1:0] out_delay_value,
  output logic [csvfre_pkg::CODE_W-1:0]     out_origin_code,
  output logic [csvfre_pkg::CODE_W-1:0]     out_dest_code,
  input  logic                              cfg_wr_en,
  input  logic [csvfre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csvfre_pkg::COL_W-1:0]      cfg_data
);

  // Column registers
  logic [csvfre_pkg::COL_W-1:0] day_col_r, delay_col_r, origin_col_r, dest_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_col_r    <= csvfre_pkg::DAY_COL_RST;
      delay_col_r  <= csvfre_pkg::DELAY_COL_RST;
      origin_col_r <= csvfre_pkg::ORIGIN_COL_RST;
      dest_col_r   <= csvfre_pkg::DEST_COL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        csvfre_pkg::CFG_DAY_COL:    day_col_r    <= cfg_data;
        csvfre_pkg::CFG_DELAY_COL:  delay_col_r  <= cfg_data;
        csvfre_pkg::CFG_ORIGIN_COL: origin_col_r <= cfg_data;
        csvfre_pkg::CFG_DEST_COL:   dest_col_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                          in_valid_r;
  logic [csvfre_pkg::CHAR_W-1:0] in_char_r;
  logic                          in_last_r;
  logic                          out_valid_r;
  logic                          out_free;
  logic                          advance;
  logic                          in_accept;

  // A non-final byte never needs the output register; a line end needs it free.
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && (!in_last_r || out_free);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_char_r <= in_char_code;
      in_last_r <= in_line_end;
    end
  end

  // Line control
  csvfre_pkg::line_state_t       line_r, line_nxt;
  logic [csvfre_pkg::COL_W-1:0]  comma_r, comma_nxt, comma_inc;
  logic [csvfre_pkg::NUM_W-1:0]  day_r, day_nxt, delay_r, delay_nxt;
  logic [csvfre_pkg::CODE_W-1:0] origin_r, origin_nxt, dest_r, dest_nxt;
  csvfre_pkg::field_ctrl_t       fctrl;
  csvfre_pkg::field_stat_t       fstat;
  logic                          parsing, is_comma, is_nul;
  logic                          hit_day, hit_delay, hit_origin, hit_dest;
  logic                          end_line;

  assign parsing   = (line_r == csvfre_pkg::LINE_PARSING);
  assign is_comma  = (in_char_r == csvfre_pkg::CHAR_COMMA);
  assign is_nul    = (in_char_r == csvfre_pkg::CHAR_NUL);
  assign comma_inc = comma_r + csvfre_pkg::COL_W'(1);
  assign hit_day    = (comma_inc == day_col_r);
  assign hit_delay  = (comma_inc == delay_col_r);
  assign hit_origin = (comma_inc == origin_col_r);
  assign hit_dest   = (comma_inc == dest_col_r);
  assign end_line   = advance && in_last_r;

  // Clear wins over take: a comma closes the field, a line end clears everything.
  assign fctrl.take  = advance && parsing && !is_comma && !is_nul;
  assign fctrl.clear = (advance && parsing && is_comma) || end_line;

  csvfre_field_unit #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_field (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fctrl),
    .char_code (in_char_r),
    .stat      (fstat)
  );

  always_comb begin
    line_nxt   = line_r;
    comma_nxt  = comma_r;
    day_nxt    = day_r;
    delay_nxt  = delay_r;
    origin_nxt = origin_r;
    dest_nxt   = dest_r;
    if (advance && parsing) begin
      if (is_comma) begin
        comma_nxt = comma_inc;
        // First matching column wins when several share a comma count.
        if (hit_day || hit_delay || hit_origin || hit_dest) begin
          if (fstat.empty) begin
            line_nxt = csvfre_pkg::LINE_REJECTED;
          end else if (hit_day) begin
            day_nxt = fstat.number;
          end else if (hit_delay) begin
            delay_nxt = fstat.number;
          end else if (!fstat.exact) begin
            line_nxt = csvfre_pkg::LINE_REJECTED;
          end else if (hit_origin) begin
            origin_nxt = fstat.code;
          end else begin
            dest_nxt = fstat.code;
            line_nxt = csvfre_pkg::LINE_COMPLETE;
          end
        end
      end else if (is_nul) begin
        line_nxt = csvfre_pkg::LINE_STOPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || end_line) begin
      line_r   <= csvfre_pkg::LINE_PARSING;
      comma_r  <= '0;
      day_r    <= '0;
      delay_r  <= '0;
      origin_r <= '0;
      dest_r   <= '0;
    end else begin
      line_r   <= line_nxt;
      comma_r  <= comma_nxt;
      day_r    <= day_nxt;
      delay_r  <= delay_nxt;
      origin_r <= origin_nxt;
      dest_r   <= dest_nxt;
    end
  end

  // Result register: load on a line end, drop once taken.
  logic                          status_r;
  logic [csvfre_pkg::NUM_W-1:0]  res_day_r, res_delay_r;
  logic [csvfre_pkg::CODE_W-1:0] res_origin_r, res_dest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (end_line) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_line) begin
      status_r     <= (line_nxt != csvfre_pkg::LINE_COMPLETE);
      res_day_r    <= day_nxt;
      res_delay_r  <= delay_nxt;
      res_origin_r <= origin_nxt;
      res_dest_r   <= dest_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_record_status = status_r;
  assign out_day_value     = res_day_r;
  assign out_delay_value   = res_delay_r;
  assign out_origin_code   = res_origin_r;
  assign out_dest_code     = res_dest_r;

endmodule

/* hdl/csvfre_field_unit.sv */
// Per-field state: length, code shift register and atoi-style number parse.
module csvfre_field_unit #(
  parameter int CODE_LENGTH = csvfre_pkg::CODE_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  csvfre_pkg::field_ctrl_t        ctrl,
  input  logic [csvfre_pkg::CHAR_W-1:0]  char_code,
  output csvfre_pkg::field_stat_t        stat
);

  localparam int LEN_W = $clog2(CODE_LENGTH + 2);
  localparam int ACC_W = csvfre_pkg::NUM_W + 3;
  localparam logic [LEN_W-1:0] LEN_CODE = LEN_W'(CODE_LENGTH);

  logic [LEN_W-1:0]              length_r, length_nxt;
  logic [csvfre_pkg::CODE_W-1:0] code_r, code_nxt;
  csvfre_pkg::num_phase_t        phase_r, phase_nxt;
  logic                          neg_r, neg_nxt;
  logic [csvfre_pkg::NUM_W-1:0]  acc_r, acc_nxt;

  logic                          is_digit, is_space, is_sign;
  logic [ACC_W-1:0]              acc_wide;

  assign is_digit = (char_code >= csvfre_pkg::CHAR_ZERO) && (char_code <= csvfre_pkg::CHAR_NINE);
  assign is_space = (char_code == csvfre_pkg::CHAR_SPACE) ||
                    ((char_code >= csvfre_pkg::CHAR_TAB) && (char_code <= csvfre_pkg::CHAR_CR));
  assign is_sign  = (char_code == csvfre_pkg::CHAR_PLUS) || (char_code == csvfre_pkg::CHAR_MINUS);

  // acc * 10 + digit as two shifts and adds
  assign acc_wide = (ACC_W'(acc_r) << 3) + (ACC_W'(acc_r) << 1) +
                    ACC_W'(char_code - csvfre_pkg::CHAR_ZERO);

  always_comb begin
    length_nxt = length_r;
    code_nxt   = code_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    if (ctrl.clear) begin
      length_nxt = '0;
      code_nxt   = '0;
      phase_nxt  = csvfre_pkg::NUM_SPACE;
      neg_nxt    = 1'b0;
      acc_nxt    = '0;
    end else if (ctrl.take) begin
      if (length_r <= LEN_CODE) begin
        length_nxt = length_r + LEN_W'(1);
      end
      code_nxt = {code_r[csvfre_pkg::CODE_W-csvfre_pkg::CHAR_W-1:0], char_code};
      if ((phase_r == csvfre_pkg::NUM_SPACE) && is_space) begin
        phase_nxt = phase_r;
      end else if ((phase_r == csvfre_pkg::NUM_SPACE) && is_sign) begin
        phase_nxt = csvfre_pkg::NUM_SIGN;
        neg_nxt   = (char_code == csvfre_pkg::CHAR_MINUS);
      end else if ((phase_r != csvfre_pkg::NUM_DONE) && is_digit) begin
        phase_nxt = csvfre_pkg::NUM_DIGITS;
        if (acc_wide > ACC_W'(csvfre_pkg::NUM_MAG_MAX)) begin
          acc_nxt = csvfre_pkg::NUM_MAG_MAX;
        end else begin
          acc_nxt = acc_wide[csvfre_pkg::NUM_W-1:0];
        end
      end else begin
        phase_nxt = csvfre_pkg::NUM_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= '0;
      code_r   <= '0;
      phase_r  <= csvfre_pkg::NUM_SPACE;
      neg_r    <= 1'b0;
      acc_r    <= '0;
    end else begin
      length_r <= length_nxt;
      code_r   <= code_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // Saturated signed value; the accumulator never exceeds the negative limit.
  always_comb begin
    stat.empty = (length_r == '0);
    stat.exact = (length_r == LEN_CODE);
    stat.code  = code_r;
    if (neg_r) begin
      stat.number = '0 - acc_r;
    end else if (acc_r > csvfre_pkg::NUM_POS_MAX) begin
      stat.number = csvfre_pkg::NUM_POS_MAX;
    end else begin
      stat.number = acc_r;
    end
  end

endmodule

/* bench/csv_record_checker.sv */
// Checker for the CSV record extractor: shadow line parser, record queue and field compare.
module csv_record_checker #(
  parameter int CODE_LEN = csvfre_pkg::CODE_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [csvfre_pkg::CHAR_W-1:0]       in_char_code,
  input  logic                                in_line_end,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_record_status,
  input  logic signed [csvfre_pkg::NUM_W-1:0] out_day_value,
  input  logic signed [csvfre_pkg::NUM_W-1:0] out_delay_value,
  input  logic [csvfre_pkg::CODE_W-1:0]       out_origin_code,
  input  logic [csvfre_pkg::CODE_W-1:0]       out_dest_code,
  input  logic                                cfg_wr_en,
  input  logic [csvfre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csvfre_pkg::COL_W-1:0]        cfg_data,
  output int                                  fail_count,
  output int                                  outstanding,
  output int                                  record_count,
  output int                                  accepted_count
);
  import csvfre_pkg::*;

  typedef struct packed {
    logic              rejected;
    logic [NUM_W-1:0]  day;
    logic [NUM_W-1:0]  delay;
    logic [CODE_W-1:0] origin;
    logic [CODE_W-1:0] dest;
  } flight_record_t;

  logic [COL_W-1:0]  col_day    = DAY_COL_RST;
  logic [COL_W-1:0]  col_delay  = DELAY_COL_RST;
  logic [COL_W-1:0]  col_origin = ORIGIN_COL_RST;
  logic [COL_W-1:0]  col_dest   = DEST_COL_RST;

  logic [COL_W-1:0]  commas;
  int                fld_len;
  logic [CODE_W-1:0] code_sr;
  num_phase_t        phase;
  logic              negative;
  int unsigned       magnitude;
  logic [NUM_W-1:0]  day_q, delay_q;
  logic [CODE_W-1:0] origin_q, dest_q;
  line_state_t       line_q;

  flight_record_t    line_records[$];
  int                mismatches;
  int                results;
  int                accepted;

  function automatic void clear_field();
    fld_len   = 0;
    code_sr   = '0;
    phase     = NUM_SPACE;
    negative  = 1'b0;
    magnitude = 0;
  endfunction

  function automatic void clear_line();
    clear_field();
    commas   = '0;
    day_q    = '0;
    delay_q  = '0;
    origin_q = '0;
    dest_q   = '0;
    line_q   = LINE_PARSING;
  endfunction

  // Clamp the magnitude to the signed 16-bit range.
  function automatic logic [NUM_W-1:0] field_number();
    logic [NUM_W-1:0] mag;
    if (negative) begin
      mag = (magnitude > NUM_MAG_MAX) ? NUM_MAG_MAX : magnitude[NUM_W-1:0];
      return ~mag + 1'b1;
    end
    return (magnitude > NUM_POS_MAX) ? NUM_POS_MAX : magnitude[NUM_W-1:0];
  endfunction

  function automatic void take_char(input logic [CHAR_W-1:0] c);
    logic digit;
    logic blank;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    if (fld_len <= CODE_LEN) fld_len++;
    code_sr = {code_sr[CODE_W-CHAR_W-1:0], c};
    if (phase == NUM_SPACE && blank) return;
    if (phase == NUM_SPACE && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
      phase    = NUM_SIGN;
      negative = (c == CHAR_MINUS);
      return;
    end
    if (phase != NUM_DONE && digit) begin
      phase     = NUM_DIGITS;
      magnitude = magnitude * 10 + (c - CHAR_ZERO);
      if (magnitude > NUM_MAG_MAX) magnitude = NUM_MAG_MAX;
      return;
    end
    phase = NUM_DONE;
  endfunction

  // Earlier registers win when columns are shared.
  function automatic void close_field();
    commas = commas + 1'b1;
    if (commas == col_day || commas == col_delay || commas == col_origin ||
        commas == col_dest) begin
      if (fld_len == 0)
        line_q = LINE_REJECTED;
      else if (commas == col_day)
        day_q = field_number();
      else if (commas == col_delay)
        delay_q = field_number();
      else if (fld_len != CODE_LEN)
        line_q = LINE_REJECTED;
      else if (commas == col_origin)
        origin_q = code_sr;
      else begin
        dest_q = code_sr;
        line_q = LINE_COMPLETE;
      end
    end
    clear_field();
  endfunction

  function automatic void parse_byte(input logic [CHAR_W-1:0] c, input logic last);
    if (line_q == LINE_PARSING) begin
      if (c == CHAR_COMMA)
        close_field();
      else if (c == CHAR_NUL)
        line_q = LINE_STOPPED;
      else
        take_char(c);
    end
    if (last) begin
      line_records.push_back('{line_q != LINE_COMPLETE, day_q, delay_q, origin_q, dest_q});
      clear_line();
    end
  endfunction

  initial clear_line();

  always @(posedge clk) begin
    flight_record_t want;
    if (!rst_n) begin
      col_day    = DAY_COL_RST;
      col_delay  = DELAY_COL_RST;
      col_origin = ORIGIN_COL_RST;
      col_dest   = DEST_COL_RST;
      clear_line();
      line_records.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DAY_COL:    col_day    = cfg_data;
          CFG_DELAY_COL:  col_delay  = cfg_data;
          CFG_ORIGIN_COL: col_origin = cfg_data;
          CFG_DEST_COL:   col_dest   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_byte(in_char_code, in_line_end);
      if (out_valid && !out_stall) begin
        if (line_records.size() == 0) begin
          $error("result beat with no line waiting for it");
          mismatches++;
        end else begin
          want = line_records.pop_front();
          results++;
          if (out_record_status === 1'b0) accepted++;
          if (out_record_status !== want.rejected) begin
            $error("record_status: expected %0d, got %0d", want.rejected, out_record_status);
            mismatches++;
          end
          if (out_day_value !== want.day) begin
            $error("day_value: expected %0d, got %0d", $signed(want.day), out_day_value);
            mismatches++;
          end
          if (out_delay_value !== want.delay) begin
            $error("delay_value: expected %0d, got %0d", $signed(want.delay),
                   out_delay_value);
            mismatches++;
          end
          if (out_origin_code !== want.origin) begin
            $error("origin_code: expected %06h, got %06h", want.origin, out_origin_code);
            mismatches++;
          end
          if (out_dest_code !== want.dest) begin
            $error("dest_code: expected %06h, got %06h", want.dest, out_dest_code);
            mismatches++;
          end
        end
      end
    end
    fail_count     <= mismatches;
    outstanding    <= line_records.size();
    record_count   <= results;
    accepted_count <= accepted;
  end

endmodule

/* bench/testbench.sv */
// Top of the CSV record extractor bench: clock, reset, line stimulus, stalls and verdict.
module testbench;
  import csvfre_pkg::*;

  // Cycles without any beat or register write before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 200;

  typedef enum int {FIELD_FILLER, FIELD_DAY, FIELD_DELAY, FIELD_ORIGIN, FIELD_DEST} field_role_t;
  typedef enum int {FLAW_NONE, FLAW_EMPTY, FLAW_CODE_LEN, FLAW_NUL, FLAW_CUT} line_flaw_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic                 in_line_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_record_status;
  logic signed [NUM_W-1:0] out_day_value;
  logic signed [NUM_W-1:0] out_delay_value;
  logic [CODE_W-1:0]    out_origin_code;
  logic [CODE_W-1:0]    out_dest_code;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COL_W-1:0]     cfg_data = '0;

  int fail_count;
  int outstanding;
  int record_count;
  int accepted_count;

  // Column settings as last written, used to shape well-formed lines.
  logic [COL_W-1:0] day_col    = DAY_COL_RST;
  logic [COL_W-1:0] delay_col  = DELAY_COL_RST;
  logic [COL_W-1:0] origin_col = ORIGIN_COL_RST;
  logic [COL_W-1:0] dest_col   = DEST_COL_RST;

  logic [CHAR_W-1:0] line_bytes[$];
  bit steady = 1'b0;     // no idling on either side once set
  int bytes_sent = 0;
  int lines_sent = 0;
  int settings = 1;
  int sink_hold = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  csv_flight_record_extractor_unit u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_char_code, .in_line_end,
    .out_valid, .out_stall, .out_record_status, .out_day_value, .out_delay_value,
    .out_origin_code, .out_dest_code,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  csv_record_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_char_code, .in_line_end,
    .out_valid, .out_stall, .out_record_status, .out_day_value, .out_delay_value,
    .out_origin_code, .out_dest_code,
    .cfg_wr_en, .cfg_index, .cfg_data,
    .fail_count, .outstanding, .record_count, .accepted_count
  );

  // Result side: stall in short random bursts, never two bursts back to back.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_stall <= 1'b1;
      sink_hold <= sink_hold - 1;
    end else begin
      out_stall <= 1'b0;
      if (!steady && $urandom_range(0, 4) == 0) sink_hold <= $urandom_range(1, 3);
    end
  end

  // Hang detection: any beat, register write or reset cycle counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Present one byte and hold it until the block takes it; idle first now and then.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_line_end  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
    lines_sent++;
  endtask

  // Drop valid and wait for every record, then let any trailing byte work drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four columns back to back; lower the enable only after the last.
  task automatic set_columns(input logic [COL_W-1:0] d, dl, o, ds);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DAY_COL;    cfg_data <= d;  @(posedge clk);
    cfg_index <= CFG_DELAY_COL;  cfg_data <= dl; @(posedge clk);
    cfg_index <= CFG_ORIGIN_COL; cfg_data <= o;  @(posedge clk);
    cfg_index <= CFG_DEST_COL;   cfg_data <= ds; @(posedge clk);
    cfg_wr_en <= 1'b0;
    day_col    = d;
    delay_col  = dl;
    origin_col = o;
    dest_col   = ds;
    settings++;
  endtask

  // Any byte but comma and zero.
  function automatic logic [CHAR_W-1:0] any_text_byte();
    logic [CHAR_W-1:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CHAR_COMMA);
    return c;
  endfunction

  function automatic int reach(input logic [COL_W-1:0] col);
    return (col == 0) ? 64 : int'(col);
  endfunction

  function automatic field_role_t role_of(input int k);
    logic [COL_W-1:0] n;
    n = k[COL_W-1:0];
    if (n == day_col)    return FIELD_DAY;
    if (n == delay_col)  return FIELD_DELAY;
    if (n == origin_col) return FIELD_ORIGIN;
    if (n == dest_col)   return FIELD_DEST;
    return FIELD_FILLER;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic add_filler(input int n);
    repeat (n) line_bytes.push_back($urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 25))
                                                         : any_text_byte());
  endtask

  task automatic add_code(input int n);
    repeat (n) line_bytes.push_back($urandom_range(0, 3) == 0 ? any_text_byte()
                                                              : 8'(8'h41 + $urandom_range(0, 25)));
  endtask

  // Leading blanks, optional sign, digits (long runs saturate), now and then junk after.
  task automatic add_number();
    int digits;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2))
        line_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE
                                                  : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
    case ($urandom_range(0, 3))
      0: line_bytes.push_back(CHAR_PLUS);
      1: line_bytes.push_back(CHAR_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0)
      digits = 0;
    else if ($urandom_range(0, 4) == 0)
      digits = $urandom_range(5, 7);
    else
      digits = $urandom_range(1, 3);
    repeat (digits) line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 5) == 0) line_bytes.push_back(any_text_byte());
  endtask

  // Build a line that follows the columns, with at most one deliberate flaw.
  task automatic build_line(input line_flaw_t flaw);
    int last_comma;
    int len;
    field_role_t target;
    field_role_t r;
    line_bytes.delete();
    last_comma = reach(day_col);
    if (reach(delay_col) > last_comma)  last_comma = reach(delay_col);
    if (reach(origin_col) > last_comma) last_comma = reach(origin_col);
    if (reach(dest_col) > last_comma)   last_comma = reach(dest_col);
    if (flaw == FLAW_CODE_LEN)
      target = $urandom_range(0, 1) ? FIELD_ORIGIN : FIELD_DEST;
    else
      target = field_role_t'($urandom_range(FIELD_DAY, FIELD_DEST));
    for (int k = 1; k <= last_comma; k++) begin
      r = role_of(k);
      if (!(flaw == FLAW_EMPTY && r == target)) begin
        case (r)
          FIELD_DAY, FIELD_DELAY: add_number();
          FIELD_ORIGIN, FIELD_DEST: begin
            len = CODE_LENGTH_DEF;
            if (flaw == FLAW_CODE_LEN && r == target)
              len = $urandom_range(0, 1) ? $urandom_range(1, 2) : $urandom_range(4, 7);
            add_code(len);
          end
          default: add_filler($urandom_range(0, 2));
        endcase
      end
      line_bytes.push_back(CHAR_COMMA);
    end
    add_filler($urandom_range(0, 3));
    if (flaw == FLAW_NUL)
      line_bytes.insert($urandom_range(0, line_bytes.size() - 1), CHAR_NUL);
    if (flaw == FLAW_CUT) begin
      len = $urandom_range(1, line_bytes.size() - 1);
      while (line_bytes.size() > len) void'(line_bytes.pop_back());
    end
  endtask

  // Mostly clean lines, some broken ones, a little raw noise heavy on commas.
  task automatic random_line();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)
      build_line(FLAW_NONE);
    else if (pick < 9)
      build_line(line_flaw_t'($urandom_range(FLAW_EMPTY, FLAW_CUT)));
    else begin
      line_bytes.delete();
      repeat ($urandom_range(1, 24)) begin
        pick = $urandom_range(0, 15);
        if (pick < 4)
          line_bytes.push_back(CHAR_COMMA);
        else if (pick == 4)
          line_bytes.push_back(CHAR_NUL);
        else
          line_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    send_line();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturation both ways, a top-bit byte in the origin, skip after completion.
    line_bytes.delete();
    add_text("-40000,\t99999,AB");
    line_bytes.push_back(8'hFF);
    add_text(",XYZ,Q");
    send_line();
    // A zero byte stops the line; the day taken before it still shows.
    line_bytes.delete();
    add_text("7,");
    line_bytes.push_back(CHAR_NUL);
    send_line();
    // A line that ends while still parsing.
    line_bytes.delete();
    add_text("5");
    send_line();

    repeat (8) random_line();

    // Shared columns: day hides delay, destination completes early.
    set_columns(6'd1, 6'd1, 6'd2, 6'd3);
    repeat (8) random_line();

    // Extremes: the destination sits on the 64th comma, where the count wraps.
    set_columns(6'd61, 6'd62, 6'd63, 6'd0);
    repeat (2) begin
      build_line(FLAW_NONE);
      send_line();
    end

    repeat (2) begin
      set_columns(6'($urandom_range(1, 5)), 6'($urandom_range(1, 5)),
                  6'($urandom_range(1, 5)), 6'($urandom_range(1, 5)));
      repeat (8) random_line();
    end

    // Closing stretch at full rate on both sides, back on the reset columns.
    steady = 1'b1;
    set_columns(DAY_COL_RST, DELAY_COL_RST, ORIGIN_COL_RST, DEST_COL_RST);
    repeat (8) random_line();

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (outstanding != 0) $error("%0d expected records never arrived", outstanding);
    $display("testbench: %0d bytes in %0d lines under %0d column settings",
             bytes_sent, lines_sent, settings);
    $display("testbench: %0d records compared, %0d of them accepted",
             record_count, accepted_count);
    if (fail_count == 0 && outstanding == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
